// File: hw/rtl/tpf_pkg.sv
// Shared types and constants of the touch pen filter.
`default_nettype none

package tpf_pkg;

    localparam int unsigned PosW   = 10;
    localparam int unsigned PressW = 10;
    localparam int unsigned CountW = 8;
    localparam int unsigned PrevW  = 14;

    // Far position loaded while the pen is lifted, so a new touch starts rejected
    localparam logic [PrevW-1:0] FarPos = 14'd10000;

    localparam logic [PressW-1:0] TriggerReset = 10'd900;
    localparam logic [PosW-1:0]   JitterReset  = 10'd50;
    localparam logic [CountW-1:0] ReleaseReset = 8'd5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRESSURE_TRIGGER = 2'd0,
        CFG_JITTER_LIMIT     = 2'd1,
        CFG_RELEASE_TICKS    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PosW-1:0]   sample_x;
        logic [PosW-1:0]   sample_y;
        logic [PressW-1:0] sample_pressure;
    } t_sample;

    typedef struct packed {
        logic [PosW-1:0] pos_x;
        logic [PosW-1:0] pos_y;
        logic            touching;
    } t_report;

    typedef struct packed {
        logic [PressW-1:0] pressure_trigger;
        logic [PosW-1:0]   jitter_limit;
        logic [CountW-1:0] release_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/tpf_sample_if.sv
// Sample channel: valid/ready handshake carrying one ADC sample.
`default_nettype none

interface tpf_sample_if;
    import tpf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tpf_report_if.sv
// Report channel: valid/ready handshake carrying one position report.
`default_nettype none

interface tpf_report_if;
    import tpf_pkg::*;

    logic    valid;
    logic    ready;
    t_report data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tpf_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface tpf_cfg_if;
    import tpf_pkg::*;

    logic              valid;
    logic              ready;
    t_cfg_idx          index;
    logic [PosW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tpf_cfg_regs.sv
// Configuration register file of the touch pen filter.
`default_nettype none

module tpf_cfg_regs (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tpf_cfg_if.sink    i_cfg,
    output tpf_pkg::t_cfg o_cfg
);
    import tpf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Always take a write
    assign i_cfg.ready = 1'b1;

    // Decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PRESSURE_TRIGGER: n_cfg.pressure_trigger = i_cfg.data;
                CFG_JITTER_LIMIT:     n_cfg.jitter_limit     = i_cfg.data;
                CFG_RELEASE_TICKS:    n_cfg.release_ticks    = i_cfg.data[CountW-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pressure_trigger <= TriggerReset;
            r_cfg.jitter_limit     <= JitterReset;
            r_cfg.release_ticks    <= ReleaseReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/tpf_core.sv
// Filter state and combinational jitter / debounce decision for one sample.
`default_nettype none

module tpf_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire tpf_pkg::t_sample i_sample,
    input  wire tpf_pkg::t_cfg    i_cfg,
    output logic                  o_produce,
    output tpf_pkg::t_report      o_report
);
    import tpf_pkg::*;

    logic [PrevW-1:0]  r_prev_x, r_prev_y, n_prev_x, n_prev_y;
    logic [PosW-1:0]   r_avg_x, r_avg_y, n_avg_x, n_avg_y;
    logic              r_pen_down, n_pen_down;
    logic [CountW-1:0] r_count, n_count;

    logic              touch;
    logic [PrevW-1:0]  ext_x, ext_y, diff_x, diff_y, ext_limit;
    logic              accept;
    logic [PrevW:0]    sum_x, sum_y;
    logic [PosW-1:0]   new_avg_x, new_avg_y;

    // Compare and average against the previous touching sample
    always_comb begin
        touch     = i_sample.sample_pressure < i_cfg.pressure_trigger;
        ext_x     = {{(PrevW-PosW){1'b0}}, i_sample.sample_x};
        ext_y     = {{(PrevW-PosW){1'b0}}, i_sample.sample_y};
        ext_limit = {{(PrevW-PosW){1'b0}}, i_cfg.jitter_limit};
        diff_x    = (r_prev_x >= ext_x) ? (r_prev_x - ext_x) : (ext_x - r_prev_x);
        diff_y    = (r_prev_y >= ext_y) ? (r_prev_y - ext_y) : (ext_y - r_prev_y);
        accept    = (diff_x < ext_limit) && (diff_y < ext_limit);
        sum_x     = {1'b0, r_prev_x} + {1'b0, ext_x};
        sum_y     = {1'b0, r_prev_y} + {1'b0, ext_y};
        new_avg_x = sum_x[PosW:1];
        new_avg_y = sum_y[PosW:1];
    end

    // Next state and report
    always_comb begin
        n_prev_x   = r_prev_x;
        n_prev_y   = r_prev_y;
        n_avg_x    = r_avg_x;
        n_avg_y    = r_avg_y;
        n_pen_down = r_pen_down;
        n_count    = r_count;
        o_produce  = 1'b0;
        o_report.pos_x    = r_avg_x;
        o_report.pos_y    = r_avg_y;
        o_report.touching = 1'b0;
        if (touch) begin
            n_prev_x = ext_x;
            n_prev_y = ext_y;
            if (accept) begin
                n_avg_x    = new_avg_x;
                n_avg_y    = new_avg_y;
                n_pen_down = 1'b1;
                n_count    = i_cfg.release_ticks;
                o_produce  = 1'b1;
                o_report.pos_x    = new_avg_x;
                o_report.pos_y    = new_avg_y;
                o_report.touching = 1'b1;
            end
        end else begin
            n_prev_x = FarPos;
            n_prev_y = FarPos;
            if (r_pen_down) begin
                if (r_count == '0) begin
                    // Countdown exhausted: report pen-up
                    n_pen_down = 1'b0;
                    o_produce  = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
        end
    end

    // Update state once per sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_avg_x    <= '0;
            r_avg_y    <= '0;
            r_pen_down <= 1'b0;
            r_count    <= '0;
        end else if (i_fire) begin
            r_prev_x   <= n_prev_x;
            r_prev_y   <= n_prev_y;
            r_avg_x    <= n_avg_x;
            r_avg_y    <= n_avg_y;
            r_pen_down <= n_pen_down;
            r_count    <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/touch_pen_filter_unit.sv
// Top level of the touch pen filter: input register, filter core, report register.
//
// Usage:
//   i_sample  (sink)  takes one ADC sample per transaction: x, y and pressure.
//   o_report  (source) gives zero or one report per sample: averaged x, y and
//             a touching flag (1 pen-down, 0 pen-up).
//   i_cfg     (sink)  writes pressure_trigger (0), jitter_limit (1) and
//             release_ticks (2); it is always ready. Write only while idle.
// Path: a sample is captured in the input register; when it advances, its
//   report, if any, enters the report register, from which o_report offers
//   it until it is taken.
// Throughput: one sample per cycle while no stall holds the input register. Filter state updates in the same cycle as
//   the decision, so consecutive samples see each other's results.
// Reset (synchronous, active low): both stages empty, history and pen state
//   cleared, registers back to 900 / 50 / 5.
// Stall: a held report blocks only a sample that would produce another
//   report; samples producing nothing still pass. Once the input register is
//   occupied and cannot advance, i_sample.ready drops.
`default_nettype none

module touch_pen_filter_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpf_sample_if.sink   i_sample,
    tpf_report_if.source o_report,
    tpf_cfg_if.sink      i_cfg
);
    import tpf_pkg::*;

    t_cfg    cfg;
    logic    r_in_valid;
    t_sample r_in;
    logic    r_out_valid;
    t_report r_out;
    logic    produce;
    t_report report;
    logic    advance;

    tpf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tpf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_sample  (r_in),
        .i_cfg     (cfg),
        .o_produce (produce),
        .o_report  (report)
    );

    // Advance the held sample when its report has room or it makes none
    assign advance        = r_in_valid && (!r_out_valid || o_report.ready || !produce);
    assign i_sample.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in <= i_sample.data;
        end
    end

    // Report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produce) begin
            r_out_valid <= 1'b1;
        end else if (o_report.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produce) begin
            r_out <= report;
        end
    end

    assign o_report.valid = r_out_valid;
    assign o_report.data  = r_out;

endmodule

`default_nettype wire
